// File: rtl/assert_macros.svh
// Assertion macros shared by the motion centroid RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check, disabled while reset is held.
`define FDMC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication check, disabled while reset is held.
`define FDMC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: rtl/fdmc_pkg.sv
// Shared types and constants of the frame difference motion centroid unit.
`timescale 1ns / 1ps

package fdmc_pkg;

    localparam int CH_W  = 8;
    localparam int PIX_W = 3 * CH_W;
    localparam int CFG_W = 10;
    localparam int TOT_W = 18;
    localparam int CEN_W = 9;

    localparam logic [CH_W-1:0]  CH_FULL        = 8'hFF;
    localparam logic [CH_W-1:0]  ERR_MARGIN_RST = 8'd20;
    localparam logic [CFG_W-1:0] FRAME_W_RST    = 10'd320;
    localparam logic [CFG_W-1:0] FRAME_H_RST    = 10'd240;

    typedef enum logic [1:0] {
        CFG_ERR_MARGIN = 2'd0,
        CFG_FRAME_W    = 2'd1,
        CFG_FRAME_H    = 2'd2
    } t_cfg_idx;

    // Controller to datapath.
    typedef struct packed {
        logic accept;
        logic commit;
        logic div_start;
        logic div_sel_y;
        logic cap_x;
        logic cap_y;
        logic load_out;
    } t_ctl_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic have_prev;
        logic last;
        logic div_done;
        logic out_free;
    } t_ctl_sts;

endpackage

// File: rtl/fdmc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module fdmc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 262144
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/fdmc_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module fdmc_div #(
    parameter int DVD_W = 27,
    parameter int DVS_W = 18
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int SW = $clog2(DVD_W);
    localparam logic [SW-1:0] STEP_LAST = SW'(DVD_W - 1);

    logic             r_busy;
    logic             r_done;
    logic [SW-1:0]    r_step;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;

    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   rem_df;
    logic             ge;
    logic [DVS_W-1:0] rem_nx;

    always_comb begin
        rem_sh = {r_rem, r_quo[DVD_W-1]};
        rem_df = rem_sh - {1'b0, r_dvs};
        ge     = rem_sh >= {1'b0, r_dvs};
        rem_nx = ge ? rem_df[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == STEP_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_step <= r_step + SW'(1);
            end
        end
    end

    // Shift the dividend out at the top while quotient bits enter at the bottom.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DVD_W-2:0], ge};
            r_rem <= rem_nx;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    `FDMC_ASSERT_IMP(a_div_no_restart, i_clk, i_rst_n, i_start, !r_busy,
        "divider started while busy")

endmodule

// File: rtl/fdmc_dp.sv
// Datapath: frame store, pixel compare, frame sums, centroid divide, output stage.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module fdmc_dp #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fdmc_pkg::t_ctl_cmd            i_cmd,
    output fdmc_pkg::t_ctl_sts            o_sts,
    input  logic [fdmc_pkg::CH_W-1:0]     i_red,
    input  logic [fdmc_pkg::CH_W-1:0]     i_green,
    input  logic [fdmc_pkg::CH_W-1:0]     i_blue,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_index,
    input  logic [fdmc_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic [fdmc_pkg::CH_W-1:0]     o_out_red,
    output logic [fdmc_pkg::CH_W-1:0]     o_out_green,
    output logic [fdmc_pkg::CH_W-1:0]     o_out_blue,
    output logic                          o_pixel_moved,
    output logic                          o_frame_last,
    output logic                          o_motion_found,
    output logic [fdmc_pkg::TOT_W-1:0]    o_moved_total,
    output logic [fdmc_pkg::CEN_W-1:0]    o_centroid_x,
    output logic [fdmc_pkg::CEN_W-1:0]    o_centroid_y
);

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CNTW  = $clog2((DEPTH + 1) / 2 + 1);
    localparam int SUMW  = CNTW + ((XW > YW) ? XW : YW);
    localparam int CHW   = fdmc_pkg::CH_W;

    function automatic logic ch_within(input logic [CHW-1:0] a, input logic [CHW-1:0] b,
                                       input logic [CHW-1:0] m);
        logic [CHW-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d <= m;
    endfunction

    // Configuration registers.
    logic [CHW-1:0]             r_err_margin;
    logic [fdmc_pkg::CFG_W-1:0] r_frame_w;
    logic [fdmc_pkg::CFG_W-1:0] r_frame_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_margin <= fdmc_pkg::ERR_MARGIN_RST;
            r_frame_w    <= fdmc_pkg::FRAME_W_RST;
            r_frame_h    <= fdmc_pkg::FRAME_H_RST;
        end else if (i_cfg_we) begin
            unique case (fdmc_pkg::t_cfg_idx'(i_cfg_index))
                fdmc_pkg::CFG_ERR_MARGIN: r_err_margin <= i_cfg_data[CHW-1:0];
                fdmc_pkg::CFG_FRAME_W:    r_frame_w    <= i_cfg_data;
                fdmc_pkg::CFG_FRAME_H:    r_frame_h    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamped size minus one: zero counts as one, oversize counts as the maximum.
    logic [XW-1:0] w_m1;
    logic [YW-1:0] h_m1;

    always_comb begin
        if (r_frame_w == '0) begin
            w_m1 = '0;
        end else if (32'(r_frame_w) > 32'(MAX_WIDTH)) begin
            w_m1 = XW'(MAX_WIDTH - 1);
        end else begin
            w_m1 = XW'(r_frame_w - 10'd1);
        end
        if (r_frame_h == '0) begin
            h_m1 = '0;
        end else if (32'(r_frame_h) > 32'(MAX_HEIGHT)) begin
            h_m1 = YW'(MAX_HEIGHT - 1);
        end else begin
            h_m1 = YW'(r_frame_h - 10'd1);
        end
    end

    // Scan position and frame sums.
    logic [XW-1:0]   r_col;
    logic [YW-1:0]   r_row;
    logic [SUMW-1:0] r_sum_x;
    logic [SUMW-1:0] r_sum_y;
    logic [CNTW-1:0] r_cnt;
    logic            r_have_prev;

    logic [fdmc_pkg::PIX_W-1:0] r_pix;
    logic [fdmc_pkg::PIX_W-1:0] stored;
    logic [AW-1:0]              pix_addr;

    assign pix_addr = AW'(r_row) * AW'(MAX_WIDTH) + AW'(r_col);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pix <= {i_red, i_green, i_blue};
        end
    end

    fdmc_ram #(
        .WIDTH (fdmc_pkg::PIX_W),
        .DEPTH (DEPTH)
    ) u_frame_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit),
        .i_waddr (pix_addr),
        .i_wdata (r_pix),
        .i_re    (i_cmd.accept),
        .i_raddr (pix_addr),
        .o_rdata (stored)
    );

    logic            chk_even;
    logic            all_within;
    logic            moved;
    logic            row_end;
    logic            last;
    logic [SUMW-1:0] sum_x_nx;
    logic [SUMW-1:0] sum_y_nx;
    logic [CNTW-1:0] cnt_nx;

    always_comb begin
        chk_even   = ~(r_col[0] ^ r_row[0]);
        all_within = ch_within(r_pix[23:16], stored[23:16], r_err_margin)
                   && ch_within(r_pix[15:8], stored[15:8], r_err_margin)
                   && ch_within(r_pix[7:0], stored[7:0], r_err_margin);
        moved      = r_have_prev && chk_even && !all_within;
        row_end    = r_col >= w_m1;
        last       = row_end && (r_row >= h_m1);
        sum_x_nx   = r_sum_x + (moved ? SUMW'(r_col) : '0);
        sum_y_nx   = r_sum_y + (moved ? SUMW'(r_row) : '0);
        cnt_nx     = r_cnt + CNTW'(moved);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_cnt       <= '0;
            r_have_prev <= 1'b0;
        end else if (i_cmd.commit) begin
            if (last) begin
                r_col       <= '0;
                r_row       <= '0;
                r_sum_x     <= '0;
                r_sum_y     <= '0;
                r_cnt       <= '0;
                r_have_prev <= 1'b1;
            end else begin
                r_sum_x <= sum_x_nx;
                r_sum_y <= sum_y_nx;
                r_cnt   <= cnt_nx;
                if (row_end) begin
                    r_col <= '0;
                    r_row <= r_row + YW'(1);
                end else begin
                    r_col <= r_col + XW'(1);
                end
            end
        end
    end

    // Result held between compare and output load.
    logic [fdmc_pkg::PIX_W-1:0] r_res_pix;
    logic                       r_res_moved;
    logic                       r_res_last;
    logic [SUMW-1:0]            r_dvx;
    logic [SUMW-1:0]            r_dvy;
    logic [CNTW-1:0]            r_tot;

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_res_pix   <= moved ? {fdmc_pkg::CH_FULL, fdmc_pkg::CH_FULL, fdmc_pkg::CH_FULL}
                                 : r_pix;
            r_res_moved <= moved;
            r_res_last  <= last;
            if (last) begin
                r_dvx <= sum_x_nx;
                r_dvy <= sum_y_nx;
                r_tot <= cnt_nx;
            end
        end
    end

    // Shared divider: x sum first, then y sum.
    logic                       div_done;
    logic [SUMW-1:0]            div_quo;
    logic [fdmc_pkg::CEN_W-1:0] r_cx;
    logic [fdmc_pkg::CEN_W-1:0] r_cy;
    logic                       tot_zero;

    assign tot_zero = (r_tot == '0);

    fdmc_div #(
        .DVD_W (SUMW),
        .DVS_W (CNTW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (i_cmd.div_sel_y ? r_dvy : r_dvx),
        .i_divisor  (r_tot),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_x) begin
            r_cx <= tot_zero ? '0 : fdmc_pkg::CEN_W'(div_quo);
        end
        if (i_cmd.cap_y) begin
            r_cy <= tot_zero ? '0 : fdmc_pkg::CEN_W'(div_quo);
        end
    end

    // Output register.
    logic r_out_valid;
    logic out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_out_red      <= r_res_pix[23:16];
            o_out_green    <= r_res_pix[15:8];
            o_out_blue     <= r_res_pix[7:0];
            o_pixel_moved  <= r_res_moved;
            o_frame_last   <= r_res_last;
            o_motion_found <= r_res_last && !tot_zero;
            o_moved_total  <= r_res_last ? fdmc_pkg::TOT_W'(r_tot) : '0;
            o_centroid_x   <= r_res_last ? r_cx : '0;
            o_centroid_y   <= r_res_last ? r_cy : '0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_sts.have_prev = r_have_prev;
    assign o_sts.last      = last;
    assign o_sts.div_done  = div_done;
    assign o_sts.out_free  = out_free;

    `FDMC_ASSERT_IMP(a_load_when_free, i_clk, i_rst_n, i_cmd.load_out,
        !r_out_valid || !i_out_stall, "output overwritten while held")
    `FDMC_ASSERT_IMP(a_summary_only_last, i_clk, i_rst_n, r_out_valid && !o_frame_last,
        !o_motion_found && (o_moved_total == '0) && (o_centroid_x == '0)
        && (o_centroid_y == '0), "summary fields set off the last pixel")

endmodule

// File: rtl/fdmc_ctrl.sv
// Controller: sequences accept, compare, centroid divide and output load.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module fdmc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  fdmc_pkg::t_ctl_sts i_sts,
    output fdmc_pkg::t_ctl_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_DIVX,
        S_WAITX,
        S_DIVY,
        S_WAITY,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.commit = 1'b1;
                if (!i_sts.have_prev) begin
                    n_state = S_IDLE;
                end else if (i_sts.last) begin
                    n_state = S_DIVX;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_DIVX: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_WAITX;
            end
            S_WAITX: begin
                if (i_sts.div_done) begin
                    o_cmd.cap_x = 1'b1;
                    n_state     = S_DIVY;
                end
            end
            S_DIVY: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel_y = 1'b1;
                n_state         = S_WAITY;
            end
            S_WAITY: begin
                if (i_sts.div_done) begin
                    o_cmd.cap_y = 1'b1;
                    n_state     = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    `FDMC_ASSERT_IMP(a_done_in_wait, i_clk, i_rst_n, i_sts.div_done,
        (r_state == S_WAITX) || (r_state == S_WAITY), "divider done outside a wait state")

endmodule

// File: rtl/frame_difference_motion_centroid_unit.sv
// Top level of the frame difference motion centroid unit.
`timescale 1ns / 1ps

// Pixel input channel (i_red/i_green/i_blue, i_in_valid, o_in_stall): raster order,
// x fastest. An item is taken on a clock edge with valid high and stall low.
// Result channel (o_out_*, o_out_valid, i_out_stall): one item per pixel once the
// first frame after reset has filled the frame store; the first frame gives none.
// The last pixel of a frame also carries moved count, motion flag and centroid.
// Configuration channel (i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data): index 0
// error margin, 1 frame width, 2 frame height; ready is always high. Write only
// while the unit is idle.
// Steps per item: accept and frame-store read, compare and store write, output
// load; input stalls until an item is done, so a new pixel waits for the last. The
// last pixel of a frame adds two passes of the shared bit-serial divider, one
// quotient bit per cycle over the sum width (27 bits at the default sizes).
// The result turns valid with the output load, after the divide passes on the
// last pixel.
// A stalled result holds in the output register; the next pixel may already be
// taken and compared, and waits in the load step until the output is free.
// Reset (synchronous, active low) restores register defaults and restarts with
// a fresh first frame; the frame store needs no clearing.
module frame_difference_motion_centroid_unit #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Pixel input
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [fdmc_pkg::CH_W-1:0]  i_red,
    input  logic [fdmc_pkg::CH_W-1:0]  i_green,
    input  logic [fdmc_pkg::CH_W-1:0]  i_blue,
    // Configuration writes
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [1:0]                 i_cfg_index,
    input  logic [fdmc_pkg::CFG_W-1:0] i_cfg_data,
    // Result output
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [fdmc_pkg::CH_W-1:0]  o_out_red,
    output logic [fdmc_pkg::CH_W-1:0]  o_out_green,
    output logic [fdmc_pkg::CH_W-1:0]  o_out_blue,
    output logic                       o_pixel_moved,
    output logic                       o_frame_last,
    output logic                       o_motion_found,
    output logic [fdmc_pkg::TOT_W-1:0] o_moved_total,
    output logic [fdmc_pkg::CEN_W-1:0] o_centroid_x,
    output logic [fdmc_pkg::CEN_W-1:0] o_centroid_y
);

    fdmc_pkg::t_ctl_cmd cmd;
    fdmc_pkg::t_ctl_sts sts;

    // Registers take writes in any cycle.
    assign o_cfg_ready = 1'b1;

    // Sequence each item: accept, compare, optional divide, load; first-frame items end after compare.
    fdmc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Hold the frame store, sums, divider and output register.
    fdmc_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_red          (i_red),
        .i_green        (i_green),
        .i_blue         (i_blue),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_out_red      (o_out_red),
        .o_out_green    (o_out_green),
        .o_out_blue     (o_out_blue),
        .o_pixel_moved  (o_pixel_moved),
        .o_frame_last   (o_frame_last),
        .o_motion_found (o_motion_found),
        .o_moved_total  (o_moved_total),
        .o_centroid_x   (o_centroid_x),
        .o_centroid_y   (o_centroid_y)
    );

endmodule
